@@ hw/rtl/rpt_pkg.sv @@
// shared types and constants of the replication progress tracker
`timescale 1ns / 1ps

package rpt_pkg;

  localparam int NUM_PEERS_DEF = 16;
  localparam int IDX_W = 64;
  localparam int BATCH_W = 16;
  localparam int SLOT_IN_W = 4;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SLOT_IN_W-1:0] SELF_SLOT_RST = '0;
  localparam logic [BATCH_W-1:0] MAX_BATCH_RST = 16'd64;

  typedef enum logic [2:0] {
    ACT_ADD       = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_SELF      = 3'd2,
    ACT_APPEND    = 3'd3,
    ACT_HEARTBEAT = 3'd4,
    ACT_RESPONSE  = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_REMOVE,
    OP_SELF,
    OP_APPEND,
    OP_HEARTBEAT,
    OP_RESPONSE
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_NOCHG   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_BUSY    = 3'd3,
    ST_FAKE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_EXEC
  } bst_t;

  typedef enum logic {
    REG_SELF_SLOT = 1'b0,
    REG_MAX_BATCH = 1'b1
  } reg_t;

  typedef struct packed {
    op_t                  op;
    logic                 in_range;
    logic [SLOT_IN_W-1:0] slot;
    logic [IDX_W-1:0]     log_index;
    logic [IDX_W-1:0]     li_inc;
    logic                 rejected;
    logic [IDX_W-1:0]     peer_next;
    logic [IDX_W-1:0]     pn_dec;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]   next;
    logic [IDX_W-1:0]   match;
    logic [BATCH_W-1:0] batch;
    logic               pend;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   send_index;
    logic [BATCH_W-1:0] send_count;
  } res_t;

endpackage

@@ hw/rtl/rpt_cfg.sv @@
// apb register file: self slot and batch limit
`timescale 1ns / 1ps

module rpt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [rpt_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [rpt_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [rpt_pkg::SLOT_IN_W-1:0]       self_slot,
  output logic [rpt_pkg::BATCH_W-1:0]         max_batch
);

  logic [rpt_pkg::SLOT_IN_W-1:0] self_slot_r, self_slot_nxt;
  logic [rpt_pkg::BATCH_W-1:0]   max_batch_r, max_batch_nxt;
  rpt_pkg::reg_t                 reg_sel;
  logic                          wr_en;

  assign reg_sel = rpt_pkg::reg_t'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  always_comb begin
    self_slot_nxt = self_slot_r;
    max_batch_nxt = max_batch_r;
    if (wr_en) begin
      unique case (reg_sel)
        rpt_pkg::REG_SELF_SLOT: self_slot_nxt = pwdata[rpt_pkg::SLOT_IN_W-1:0];
        rpt_pkg::REG_MAX_BATCH: max_batch_nxt = pwdata[rpt_pkg::BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      rpt_pkg::REG_SELF_SLOT: prdata = rpt_pkg::CFG_DATA_W'(self_slot_r);
      rpt_pkg::REG_MAX_BATCH: prdata = rpt_pkg::CFG_DATA_W'(max_batch_r);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_slot_r <= rpt_pkg::SELF_SLOT_RST;
      max_batch_r <= rpt_pkg::MAX_BATCH_RST;
    end else begin
      self_slot_r <= self_slot_nxt;
      max_batch_r <= max_batch_nxt;
    end
  end

  assign self_slot = self_slot_r;
  assign max_batch = max_batch_r;

endmodule

@@ hw/rtl/rpt_front.sv @@
// front end: accepts beats, decodes the action and queues commands
`timescale 1ns / 1ps

module rpt_front #(
  parameter int NUM_PEERS = rpt_pkg::NUM_PEERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [2:0]                        in_action,
  input  logic [rpt_pkg::SLOT_IN_W-1:0]     in_peer,
  input  logic [rpt_pkg::IDX_W-1:0]         in_log_index,
  input  logic                              in_rejected,
  input  logic [rpt_pkg::IDX_W-1:0]         in_peer_next,
  input  logic [rpt_pkg::SLOT_IN_W-1:0]     self_slot,
  input  logic                              cmd_pop,
  output logic                              cmd_empty,
  output rpt_pkg::cmd_t                     cmd
);

  rpt_pkg::cmd_t                 q_r [rpt_pkg::Q_DEPTH];
  logic [rpt_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rpt_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rpt_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  rpt_pkg::cmd_t                 dec;
  logic                          acc;
  logic                          deq;

  // classify the incoming beat
  always_comb begin
    dec           = '0;
    dec.log_index = in_log_index;
    dec.li_inc    = in_log_index + rpt_pkg::IDX_W'(1);
    dec.rejected  = in_rejected;
    dec.peer_next = in_peer_next;
    dec.pn_dec    = in_peer_next - rpt_pkg::IDX_W'(1);
    dec.slot      = in_peer;
    dec.in_range  = (32'(in_peer) < NUM_PEERS);
    unique case (rpt_pkg::act_t'(in_action))
      rpt_pkg::ACT_ADD:       dec.op = rpt_pkg::OP_ADD;
      rpt_pkg::ACT_REMOVE:    dec.op = rpt_pkg::OP_REMOVE;
      rpt_pkg::ACT_SELF: begin
        dec.op       = rpt_pkg::OP_SELF;
        dec.slot     = self_slot;
        dec.in_range = (32'(self_slot) < NUM_PEERS);
      end
      rpt_pkg::ACT_APPEND:    dec.op = rpt_pkg::OP_APPEND;
      rpt_pkg::ACT_HEARTBEAT: dec.op = rpt_pkg::OP_HEARTBEAT;
      rpt_pkg::ACT_RESPONSE:  dec.op = rpt_pkg::OP_RESPONSE;
      default:                dec.op = rpt_pkg::OP_NOP;
    endcase
  end

  assign full      = (cnt_r == rpt_pkg::Q_CNT_W'(rpt_pkg::Q_DEPTH));
  assign cmd_empty = (cnt_r == '0);
  assign acc       = push & ~full;
  assign deq       = cmd_pop & ~cmd_empty;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (acc) begin
      wr_ptr_nxt = (wr_ptr_r == rpt_pkg::Q_PTR_W'(rpt_pkg::Q_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == rpt_pkg::Q_PTR_W'(rpt_pkg::Q_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (acc && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

@@ hw/rtl/rpt_back.sv @@
// back end: per-peer progress table and the read-modify-write sequencer
`timescale 1ns / 1ps

module rpt_back #(
  parameter int NUM_PEERS = rpt_pkg::NUM_PEERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpt_pkg::cmd_t                 cmd,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output rpt_pkg::res_t                 res,
  input  logic [rpt_pkg::BATCH_W-1:0]   max_batch
);

  localparam int SLOT_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;

  rpt_pkg::bst_t                 state_r, state_nxt;
  rpt_pkg::entry_t               mem_r [NUM_PEERS];
  rpt_pkg::entry_t               rd_r;
  rpt_pkg::cmd_t                 cmd_r;
  logic [NUM_PEERS-1:0]          valid_r;
  logic                          known_r;
  logic [rpt_pkg::IDX_W-1:0]     room_r;
  logic [rpt_pkg::IDX_W-1:0]     half_r;
  logic                          stale_r;
  logic                          same_r;

  logic [SLOT_W-1:0]             rd_idx;
  logic [SLOT_W-1:0]             wr_idx;
  logic                          start;
  logic                          mem_we;
  rpt_pkg::entry_t               mem_wd;
  logic                          vld_we;
  logic                          vld_wd;
  logic [rpt_pkg::IDX_W-1:0]     cand;
  logic [rpt_pkg::BATCH_W-1:0]   b1;
  logic [rpt_pkg::BATCH_W:0]     dbl;
  logic [rpt_pkg::BATCH_W-1:0]   grown;
  logic [rpt_pkg::BATCH_W-1:0]   cnt;

  assign rd_idx = SLOT_W'(cmd.slot);
  assign wr_idx = SLOT_W'(cmd_r.slot);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpt_pkg::B_IDLE: if (!cmd_empty && !res_full) state_nxt = rpt_pkg::B_CALC;
      rpt_pkg::B_CALC: state_nxt = rpt_pkg::B_EXEC;
      rpt_pkg::B_EXEC: state_nxt = rpt_pkg::B_IDLE;
      default:         state_nxt = rpt_pkg::B_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    start    = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      rpt_pkg::B_IDLE: start    = ~cmd_empty & ~res_full;
      rpt_pkg::B_CALC: ;
      rpt_pkg::B_EXEC: res_push = 1'b1;
      default: ;
    endcase
  end

  assign cmd_pop = start;

  // final step of each action
  always_comb begin
    cand  = half_r + rd_r.match;
    b1    = (rd_r.batch == '0) ? rpt_pkg::BATCH_W'(1) : rd_r.batch;
    dbl   = {b1, 1'b0};
    grown = (dbl < {1'b0, max_batch}) ? dbl[rpt_pkg::BATCH_W-1:0] : max_batch;
    cnt   = (room_r < rpt_pkg::IDX_W'(rd_r.batch)) ? room_r[rpt_pkg::BATCH_W-1:0]
                                                   : rd_r.batch;

    res            = '0;
    res.status     = rpt_pkg::ST_NOCHG;
    mem_we         = 1'b0;
    mem_wd         = rd_r;
    vld_we         = 1'b0;
    vld_wd         = 1'b0;

    if (state_r == rpt_pkg::B_EXEC) begin
      unique case (cmd_r.op)
        rpt_pkg::OP_ADD: begin
          if (!cmd_r.in_range) begin
            res.status = rpt_pkg::ST_UNKNOWN;
          end else if (!known_r) begin
            vld_we     = 1'b1;
            vld_wd     = 1'b1;
            mem_we     = 1'b1;
            mem_wd     = '{next: cmd_r.li_inc, match: '0, batch: '0, pend: 1'b0};
            res.status = rpt_pkg::ST_DONE;
          end
        end
        rpt_pkg::OP_REMOVE: begin
          if (known_r) begin
            vld_we     = 1'b1;
            res.status = rpt_pkg::ST_DONE;
          end else begin
            res.status = rpt_pkg::ST_UNKNOWN;
          end
        end
        rpt_pkg::OP_SELF: begin
          if (known_r) begin
            mem_we       = 1'b1;
            mem_wd.next  = cmd_r.li_inc;
            mem_wd.match = cmd_r.log_index;
            mem_wd.pend  = 1'b1;
            res.status   = rpt_pkg::ST_DONE;
          end
        end
        rpt_pkg::OP_APPEND: begin
          if (!known_r) begin
            res.status = rpt_pkg::ST_UNKNOWN;
          end else if (rd_r.pend) begin
            res.status = rpt_pkg::ST_BUSY;
          end else begin
            mem_we         = 1'b1;
            mem_wd.pend    = 1'b1;
            res.status     = rpt_pkg::ST_DONE;
            res.send_index = rd_r.next;
            res.send_count = cnt;
          end
        end
        rpt_pkg::OP_HEARTBEAT: begin
          if (!known_r) begin
            res.status = rpt_pkg::ST_UNKNOWN;
          end else begin
            mem_we         = 1'b1;
            mem_wd.pend    = 1'b0;
            res.status     = rpt_pkg::ST_DONE;
            res.send_index = rd_r.next;
          end
        end
        rpt_pkg::OP_RESPONSE: begin
          if (!known_r) begin
            res.status = rpt_pkg::ST_UNKNOWN;
          end else if (cmd_r.rejected) begin
            mem_we       = 1'b1;
            mem_wd.pend  = 1'b0;
            mem_wd.batch = rd_r.batch >> 1;
            if (cand == rd_r.next) begin
              res.status = rpt_pkg::ST_FAKE;
            end else begin
              mem_wd.next = cand;
              res.status  = rpt_pkg::ST_DONE;
            end
          end else if (!stale_r) begin
            mem_we      = 1'b1;
            mem_wd.pend = 1'b0;
            if (same_r) begin
              mem_wd.batch = b1;
            end else begin
              mem_wd.batch = grown;
              mem_wd.match = cmd_r.pn_dec;
              mem_wd.next  = cmd_r.peer_next;
              res.status   = rpt_pkg::ST_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpt_pkg::B_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (vld_we) begin
        valid_r[wr_idx] <= vld_wd;
      end
    end
  end

  // table read and write ports
  always_ff @(posedge clk) begin
    if (start) begin
      rd_r <= mem_r[rd_idx];
    end
    if (mem_we) begin
      mem_r[wr_idx] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r   <= cmd;
      known_r <= cmd.in_range & valid_r[rd_idx];
    end
    if (state_r == rpt_pkg::B_CALC) begin
      room_r  <= cmd_r.li_inc - rd_r.next;
      half_r  <= (rd_r.next - rd_r.match) >> 1;
      stale_r <= (cmd_r.peer_next < rd_r.next);
      same_r  <= (cmd_r.pn_dec == rd_r.match);
    end
  end

endmodule

@@ hw/rtl/rpt_rq.sv @@
// result queue between the back end and the output ports
`timescale 1ns / 1ps

module rpt_rq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_push,
  input  rpt_pkg::res_t   res_in,
  output logic            res_full,
  input  logic            pop,
  output logic            empty,
  output rpt_pkg::res_t   res_out
);

  rpt_pkg::res_t                 q_r [rpt_pkg::Q_DEPTH];
  logic [rpt_pkg::Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rpt_pkg::Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rpt_pkg::Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          enq;
  logic                          deq;

  assign res_full = (cnt_r == rpt_pkg::Q_CNT_W'(rpt_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign enq      = res_push & ~res_full;
  assign deq      = pop & ~empty;
  assign res_out  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == rpt_pkg::Q_PTR_W'(rpt_pkg::Q_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == rpt_pkg::Q_PTR_W'(rpt_pkg::Q_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

@@ hw/rtl/replication_progress_tracker_top.sv @@
// top level of the replication progress tracker
// Per-peer progress table for a replication leader.
// Input channel: push/full with action, peer, log_index, rejected and
// peer_next; a beat is taken when push is high and full is low. A two-entry
// command queue sits behind it, so beats are taken while the table is busy.
// Result channel: empty/pop; the oldest result (status, send_index,
// send_count) is on the out_ ports while empty is low, and pop takes it.
// Every input beat gives exactly one result beat, in order.
// A beat passes the command queue, the table read, calculate and write-back
// steps and the result queue; the table ends each command before the next.
// The two-entry result queue lets the table keep working while the receiver
// stalls; with both queues full, full stays high until pop. Configuration
// over APB: self_slot at 0x0, max_batch at 0x4, to be written by the user
// only while idle; the block does not enforce it. Reset (rst_n low,
// synchronous) empties both queues, frees every slot and loads self_slot 0
// and max_batch 64; no clearing pass.
`timescale 1ns / 1ps

module replication_progress_tracker_top #(
  parameter int NUM_PEERS = rpt_pkg::NUM_PEERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [2:0]                        in_action,
  input  logic [rpt_pkg::SLOT_IN_W-1:0]     in_peer,
  input  logic [rpt_pkg::IDX_W-1:0]         in_log_index,
  input  logic                              in_rejected,
  input  logic [rpt_pkg::IDX_W-1:0]         in_peer_next,
  output logic                              empty,
  input  logic                              pop,
  output logic [2:0]                        out_status,
  output logic [rpt_pkg::IDX_W-1:0]         out_send_index,
  output logic [rpt_pkg::BATCH_W-1:0]       out_send_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpt_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rpt_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rpt_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [rpt_pkg::SLOT_IN_W-1:0] self_slot;
  logic [rpt_pkg::BATCH_W-1:0]   max_batch;
  rpt_pkg::cmd_t                 cmd;
  logic                          cmd_empty;
  logic                          cmd_pop;
  rpt_pkg::res_t                 res_in;
  rpt_pkg::res_t                 res_out;
  logic                          res_push;
  logic                          res_full;

  rpt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .self_slot (self_slot),
    .max_batch (max_batch)
  );

  rpt_front #(
    .NUM_PEERS (NUM_PEERS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_action    (in_action),
    .in_peer      (in_peer),
    .in_log_index (in_log_index),
    .in_rejected  (in_rejected),
    .in_peer_next (in_peer_next),
    .self_slot    (self_slot),
    .cmd_pop      (cmd_pop),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd)
  );

  rpt_back #(
    .NUM_PEERS (NUM_PEERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .max_batch (max_batch)
  );

  rpt_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_in   (res_in),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .res_out  (res_out)
  );

  assign out_status     = res_out.status;
  assign out_send_index = res_out.send_index;
  assign out_send_count = res_out.send_count;

endmodule

@@ hw/rtl/rpt_chk.sv @@
// port-level checker of the replication progress tracker, bound to the top
`timescale 1ns / 1ps

module rpt_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              push,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [2:0]                        out_status,
  input logic [rpt_pkg::IDX_W-1:0]         out_send_index,
  input logic [rpt_pkg::BATCH_W-1:0]       out_send_count
);

  // reset leaves the result queue empty and the command queue not full
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  // a waiting result holds until popped
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) &&
                          $stable(out_send_index) && $stable(out_send_count)))
    else $error("waiting result changed before pop");

  // only defined status codes appear
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status <= rpt_pkg::ST_FAKE))
    else $error("undefined status code");

  // anything but a completed request sends nothing
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != rpt_pkg::ST_DONE) |->
      (out_send_index == '0 && out_send_count == '0))
    else $error("refused request carries send fields");

  // a nonzero count only comes with a done status
  a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_send_count != '0) |-> (out_status == rpt_pkg::ST_DONE))
    else $error("send count without done status");

endmodule

bind replication_progress_tracker_top rpt_chk u_chk (.*);

@@ bench/progress_checker.sv @@
// reply predictor and comparator for the replication progress tracker
`timescale 1ns / 1ps

module progress_checker #(
  parameter int PEERS = rpt_pkg::NUM_PEERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  logic [2:0]                     in_action,
  input  logic [rpt_pkg::SLOT_IN_W-1:0]  in_peer,
  input  logic [rpt_pkg::IDX_W-1:0]      in_log_index,
  input  logic                           in_rejected,
  input  logic [rpt_pkg::IDX_W-1:0]      in_peer_next,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [2:0]                     out_status,
  input  logic [rpt_pkg::IDX_W-1:0]      out_send_index,
  input  logic [rpt_pkg::BATCH_W-1:0]    out_send_count,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rpt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rpt_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatches,
  output int                             replies_owed
);
  import rpt_pkg::*;

  localparam int REPORT_CAP = 100;

  logic                 live      [PEERS];
  logic [IDX_W-1:0]     next_idx  [PEERS];
  logic [IDX_W-1:0]     match_idx [PEERS];
  logic [BATCH_W-1:0]   batch     [PEERS];
  logic                 waiting   [PEERS];
  logic [SLOT_IN_W-1:0] self_slot;
  logic [BATCH_W-1:0]   batch_cap;

  res_t expected_replies[$];

  function automatic res_t track_step(input logic [2:0] act, input logic [SLOT_IN_W-1:0] peer,
                                      input logic [IDX_W-1:0] li, input logic rej,
                                      input logic [IDX_W-1:0] pn);
    res_t r;
    logic inr;
    logic known;
    int s;
    logic [IDX_W-1:0] room;
    logic [IDX_W-1:0] cand;
    logic [BATCH_W:0] dbl;
    r.status = ST_NOCHG;
    r.send_index = '0;
    r.send_count = '0;
    inr = int'(peer) < PEERS;
    s = inr ? int'(peer) : 0;
    known = inr && live[s];
    case (act)
      ACT_ADD: begin
        if (!inr) begin
          r.status = ST_UNKNOWN;
        end else if (!live[s]) begin
          live[s] = 1'b1;
          next_idx[s] = li + 64'd1;
          match_idx[s] = '0;
          batch[s] = '0;
          waiting[s] = 1'b0;
          r.status = ST_DONE;
        end
      end
      ACT_REMOVE: begin
        if (known) begin
          live[s] = 1'b0;
          next_idx[s] = '0;
          match_idx[s] = '0;
          batch[s] = '0;
          waiting[s] = 1'b0;
          r.status = ST_DONE;
        end else begin
          r.status = ST_UNKNOWN;
        end
      end
      ACT_SELF: begin
        if (int'(self_slot) < PEERS && live[self_slot]) begin
          next_idx[self_slot] = li + 64'd1;
          match_idx[self_slot] = li;
          waiting[self_slot] = 1'b1;
          r.status = ST_DONE;
        end
      end
      ACT_APPEND: begin
        if (!known) begin
          r.status = ST_UNKNOWN;
        end else if (waiting[s]) begin
          r.status = ST_BUSY;
        end else begin
          room = li + 64'd1 - next_idx[s];
          r.send_index = next_idx[s];
          r.send_count = (room < 64'(batch[s])) ? room[BATCH_W-1:0] : batch[s];
          waiting[s] = 1'b1;
          r.status = ST_DONE;
        end
      end
      ACT_HEARTBEAT: begin
        if (!known) begin
          r.status = ST_UNKNOWN;
        end else begin
          waiting[s] = 1'b0;
          r.send_index = next_idx[s];
          r.status = ST_DONE;
        end
      end
      ACT_RESPONSE: begin
        if (!known) begin
          r.status = ST_UNKNOWN;
        end else if (rej) begin
          // bisect next toward match
          cand = ((next_idx[s] - match_idx[s]) >> 1) + match_idx[s];
          waiting[s] = 1'b0;
          batch[s] = batch[s] >> 1;
          if (cand == next_idx[s]) begin
            r.status = ST_FAKE;
          end else begin
            next_idx[s] = cand;
            r.status = ST_DONE;
          end
        end else if (pn < next_idx[s]) begin
          r.status = ST_NOCHG;
        end else begin
          waiting[s] = 1'b0;
          if (batch[s] == '0) batch[s] = 1;
          if (pn - 64'd1 == match_idx[s]) begin
            r.status = ST_NOCHG;
          end else begin
            match_idx[s] = pn - 64'd1;
            next_idx[s] = pn;
            dbl = {batch[s], 1'b0};
            batch[s] = (dbl < {1'b0, batch_cap}) ? dbl[BATCH_W-1:0] : batch_cap;
            r.status = ST_DONE;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [IDX_W-1:0] want,
                             input logic [IDX_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      for (int i = 0; i < PEERS; i++) begin
        live[i] = 1'b0;
        next_idx[i] = '0;
        match_idx[i] = '0;
        batch[i] = '0;
        waiting[i] = 1'b0;
      end
      self_slot = SELF_SLOT_RST;
      batch_cap = MAX_BATCH_RST;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP) $error("result beat with no reply pending");
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("send_index", want.send_index, out_send_index);
          check_field("send_count", 64'(want.send_count), 64'(out_send_count));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_SELF_SLOT, 2'b00}) self_slot = pwdata[SLOT_IN_W-1:0];
        else if (paddr == {REG_MAX_BATCH, 2'b00}) batch_cap = pwdata[BATCH_W-1:0];
      end
      if (push && !full) begin
        expected_replies.push_back(track_step(in_action, in_peer, in_log_index, in_rejected,
                                              in_peer_next));
      end
    end
    replies_owed = expected_replies.size();
  end

endmodule

@@ bench/tb.sv @@
// stimulus and verdict for the replication progress tracker
`timescale 1ns / 1ps

module tb;
  import rpt_pkg::*;

  localparam logic [2:0]       ACT_SPARE_LO = 3'd6;
  localparam logic [2:0]       ACT_SPARE_HI = 3'd7;
  localparam logic [IDX_W-1:0] TOP_IDX = '1;
  localparam int               PHASES = 8;
  localparam int               PHASE_ITEMS = 140;
  localparam int               LONG_HOLD = 300;

  typedef struct {
    logic [2:0]           action;
    logic [SLOT_IN_W-1:0] peer;
    logic [IDX_W-1:0]     log_index;
    logic                 rejected;
    logic [IDX_W-1:0]     peer_next;
  } peer_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  logic [2:0]            in_action;
  logic [SLOT_IN_W-1:0]  in_peer;
  logic [IDX_W-1:0]      in_log_index;
  logic                  in_rejected;
  logic [IDX_W-1:0]      in_peer_next;
  logic                  empty;
  logic                  pop;
  logic [2:0]            out_status;
  logic [IDX_W-1:0]      out_send_index;
  logic [BATCH_W-1:0]    out_send_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatches;
  int                    replies_owed;

  logic                  tx_gaps_on;
  logic                  rx_stalls_on;
  logic                  hold_req;
  logic [IDX_W-1:0]      lead;
  logic [SLOT_IN_W-1:0]  self_cfg;
  int                    hot_base;
  logic                  added   [16];
  logic [IDX_W-1:0]      last_pn [16];

  replication_progress_tracker_top uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_action(in_action), .in_peer(in_peer), .in_log_index(in_log_index),
    .in_rejected(in_rejected), .in_peer_next(in_peer_next),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_send_index(out_send_index),
    .out_send_count(out_send_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  progress_checker chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_action(in_action), .in_peer(in_peer), .in_log_index(in_log_index),
    .in_rejected(in_rejected), .in_peer_next(in_peer_next),
    .empty(empty), .pop(pop),
    .out_status(out_status), .out_send_index(out_send_index),
    .out_send_count(out_send_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .replies_owed(replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [IDX_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly none, often short, rarely long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic peer_req_t req(input logic [2:0] act, input logic [SLOT_IN_W-1:0] peer,
                                    input logic [IDX_W-1:0] li, input logic rej,
                                    input logic [IDX_W-1:0] pn);
    peer_req_t r;
    r.action = act;
    r.peer = peer;
    r.log_index = li;
    r.rejected = rej;
    r.peer_next = pn;
    return r;
  endfunction

  function automatic peer_req_t draw_req();
    peer_req_t r;
    int pick;
    int roll;
    pick = $urandom_range(99);
    if (pick < 80) r.peer = SLOT_IN_W'(hot_base + $urandom_range(0, 3));
    else if (pick < 90) r.peer = self_cfg;
    else r.peer = SLOT_IN_W'($urandom_range(0, 15));
    r.action = ACT_HEARTBEAT;
    r.log_index = ($urandom_range(99) < 5) ? rand64() : lead + $urandom_range(0, 3);
    r.rejected = 1'b0;
    r.peer_next = rand64();
    roll = $urandom_range(99);
    if (roll < 8) begin
      r.action = 3'($urandom_range(0, 7));
      r.peer = SLOT_IN_W'($urandom_range(0, 15));
      r.log_index = rand64();
      r.rejected = 1'($urandom_range(0, 1));
      return r;
    end
    if (!added[r.peer] && $urandom_range(99) < 70) roll = 8;
    if (roll < 16) begin
      r.action = ACT_ADD;
    end else if (roll < 20) begin
      r.action = ACT_REMOVE;
    end else if (roll < 50) begin
      r.action = (roll < 25) ? ACT_SELF : ACT_APPEND;
      lead = lead + $urandom_range(0, 5);
      if ($urandom_range(99) >= 5) r.log_index = lead;
    end else if (roll < 58) begin
      r.action = ACT_HEARTBEAT;
    end else if (roll < 88) begin
      r.action = ACT_RESPONSE;
      pick = $urandom_range(99);
      if (pick < 25) r.peer_next = last_pn[r.peer];
      else if (pick < 90) r.peer_next = lead + 64'd1 - $urandom_range(0, 4);
      last_pn[r.peer] = r.peer_next;
    end else begin
      r.action = ACT_RESPONSE;
      r.rejected = 1'b1;
    end
    return r;
  endfunction

  task automatic send_req(input peer_req_t r);
    int g;
    g = tx_gaps_on ? gap_len() : 0;
    @(negedge clk);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push <= 1'b1;
    in_action <= r.action;
    in_peer <= r.peer;
    in_log_index <= r.log_index;
    in_rejected <= r.rejected;
    in_peer_next <= r.peer_next;
    if (r.action == ACT_ADD) added[r.peer] = 1'b1;
    else if (r.action == ACT_REMOVE) added[r.peer] = 1'b0;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // stop offering, wait out every reply, then let the pipeline go quiet
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_SELF_SLOT) self_cfg = val[SLOT_IN_W-1:0];
  endtask

  task automatic run_directed();
    send_req(req(ACT_APPEND, 4'd3, 64'd20, 1'b0, '0));
    send_req(req(ACT_ADD, 4'd3, 64'd9, 1'b0, '0));
    send_req(req(ACT_ADD, 4'd3, 64'd9, 1'b0, '0));
    send_req(req(ACT_APPEND, 4'd3, 64'd20, 1'b0, '0));
    send_req(req(ACT_APPEND, 4'd3, 64'd20, 1'b0, '0));
    send_req(req(ACT_RESPONSE, 4'd3, '0, 1'b0, 64'd5));
    send_req(req(ACT_RESPONSE, 4'd3, '0, 1'b0, 64'd15));
    send_req(req(ACT_RESPONSE, 4'd3, '0, 1'b0, 64'd15));
    send_req(req(ACT_HEARTBEAT, 4'd3, '0, 1'b0, '0));
    // next past last index: wrapped room
    send_req(req(ACT_APPEND, 4'd3, 64'd10, 1'b0, '0));
    send_req(req(ACT_RESPONSE, 4'd3, '0, 1'b1, '0));
    send_req(req(ACT_RESPONSE, 4'd3, '0, 1'b1, TOP_IDX));
    send_req(req(ACT_SELF, 4'd0, TOP_IDX, 1'b0, '0));
    send_req(req(ACT_ADD, 4'd0, TOP_IDX, 1'b0, '0));
    send_req(req(ACT_SELF, 4'd0, TOP_IDX, 1'b0, '0));
    send_req(req(ACT_APPEND, 4'd0, TOP_IDX, 1'b0, '0));
    send_req(req(ACT_RESPONSE, 4'd0, '0, 1'b1, '0));
    send_req(req(ACT_HEARTBEAT, 4'd15, TOP_IDX, 1'b1, TOP_IDX));
    send_req(req(ACT_REMOVE, 4'd15, '0, 1'b0, '0));
    send_req(req(ACT_REMOVE, 4'd3, '0, 1'b0, '0));
    send_req(req(ACT_SPARE_LO, 4'd0, TOP_IDX, 1'b1, TOP_IDX));
    send_req(req(ACT_SPARE_HI, 4'd15, '0, 1'b0, '0));
    send_req(req(ACT_ADD, 4'd15, '0, 1'b0, '0));
    send_req(req(ACT_RESPONSE, 4'd15, '0, 1'b0, TOP_IDX));
    send_req(req(ACT_APPEND, 4'd15, TOP_IDX, 1'b0, '0));
  endtask

  task automatic run_phase(input int p);
    logic [SLOT_IN_W-1:0] s;
    logic [BATCH_W-1:0]   m;
    s = SLOT_IN_W'($urandom_range(0, 15));
    m = BATCH_W'($urandom_range(1, 65535));
    case (p)
      0: begin s = 4'd1; m = 16'd1; end
      1: begin s = 4'd15; m = 16'hFFFF; end
      2: begin s = 4'd0; m = 16'd0; end
      3: begin s = 4'd4; m = 16'd3; end
      5: m = 16'hFFFF;
      default: ;
    endcase
    write_reg(REG_SELF_SLOT, CFG_DATA_W'(s));
    write_reg(REG_MAX_BATCH, CFG_DATA_W'(m));
    hot_base = (p % 2 == 0) ? $urandom_range(0, 12) : ((int'(s) > 12) ? 12 : int'(s));
    case (p % 3)
      0: lead = rand64();
      1: lead = 64'($urandom_range(0, 20));
      default: lead = TOP_IDX - $urandom_range(0, 40);
    endcase
    tx_gaps_on = (p % 3 != 1) && (p != 3);
    rx_stalls_on = (p % 3 != 2);
    if (p == 3) hold_req = 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) send_req(draw_req());
    settle();
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin : drain_side
    int rx_hold;
    rx_hold = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(99) < 30) begin
        rx_hold = gap_len();
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_action = ACT_ADD;
    in_peer = '0;
    in_log_index = '0;
    in_rejected = 1'b0;
    in_peer_next = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    hold_req = 1'b0;
    lead = '0;
    self_cfg = SELF_SLOT_RST;
    hot_base = 0;
    for (int i = 0; i < 16; i++) begin
      added[i] = 1'b0;
      last_pn[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    settle();
    for (int p = 0; p < PHASES; p++) run_phase(p);
    if (mismatches == 0 && replies_owed == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
